// ----- design/ptb_pkg.sv -----
// Package for the periodic timer bank: sizes, command and status codes,
// and the item and slot record types shared by the modules.
// No dependencies.
package ptb_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int MAX_RES     = 16;

  localparam int SLOT_W     = 4;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CMP_W      = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
  localparam int EVT_CNT_W  = $clog2(MAX_RES + 1);

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CMP_W-1:0]     cmp_t;
  typedef logic [EVT_CNT_W-1:0] evt_cnt_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [DATA_W-1:0]    data_t;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_SETUP   = 3'd1;
  localparam logic [2:0] OP_START   = 3'd2;
  localparam logic [2:0] OP_STOP    = 3'd3;
  localparam logic [2:0] OP_DESTROY = 3'd4;
  localparam logic [2:0] OP_READ    = 3'd5;

  localparam logic [2:0] ST_UNUSED    = 3'd0;
  localparam logic [2:0] ST_CREATED   = 3'd1;
  localparam logic [2:0] ST_STARTED   = 3'd2;
  localparam logic [2:0] ST_RUNNING   = 3'd3;
  localparam logic [2:0] ST_STOPPED   = 3'd4;
  localparam logic [2:0] ST_DESTROYED = 3'd5;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_INFO   = 1'b1;

  typedef struct packed {
    logic [2:0] opcode;
    slot_t      slot;
    data_t      start_delay;
    data_t      period;
    logic       hard_class;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    slot_t      event_slot;
    logic       event_hard;
    data_t      info_start_delay;
    data_t      info_period;
    logic [2:0] info_state;
    logic       last;
  } out_item_t;

  typedef struct packed {
    data_t      start_delay;
    data_t      period;
    data_t      remaining;
    logic       hard;
    logic [2:0] status;
  } slot_rec_t;

  // Status of the record passing the update unit in the current cycle.
  typedef struct packed {
    logic expire;
    logic read_hit;
  } upd_res_t;

endpackage

// ----- design/ptb_cell.sv -----
// One cell of the slot ring: holds the record of one timer slot and takes
// its neighbor's record (the update unit's output at the tail) on every shift. Depends on ptb_pkg.
module ptb_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  ptb_pkg::slot_rec_t  rec_in,
  output ptb_pkg::slot_rec_t  rec_out
);

  ptb_pkg::slot_rec_t rec_r;
  ptb_pkg::slot_rec_t rec_nxt;

  always_comb begin
    rec_nxt = rec_r;
    if (shift_en) begin
      rec_nxt = rec_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else begin
      rec_r <= rec_nxt;
    end
  end

  assign rec_out = rec_r;

endmodule

// ----- design/ptb_update.sv -----
// Update unit at the head of the slot ring: applies the current command to
// the record of the slot passing by and flags expiries and readback hits.
// Depends on ptb_pkg.
module ptb_update (
  input  ptb_pkg::in_item_t   cmd,
  input  ptb_pkg::idx_t       head_idx,
  input  logic                pass_soft,
  input  ptb_pkg::slot_rec_t  rec_in,
  output ptb_pkg::slot_rec_t  rec_out,
  output ptb_pkg::upd_res_t   res
);

  logic           hit;
  logic           active;
  logic           class_ok;
  ptb_pkg::data_t init_cnt;

  assign hit      = (ptb_pkg::cmp_t'(cmd.slot) == ptb_pkg::cmp_t'(head_idx));
  assign active   = (rec_in.status == ptb_pkg::ST_STARTED) ||
                    (rec_in.status == ptb_pkg::ST_RUNNING);
  assign class_ok = (rec_in.hard == !pass_soft);

  // Initial count for set up uses the new settings, for start the stored ones.
  always_comb begin
    init_cnt = '0;
    if (cmd.opcode == ptb_pkg::OP_SETUP) begin
      init_cnt = (cmd.start_delay != '0) ? cmd.start_delay : cmd.period;
    end else begin
      init_cnt = (rec_in.start_delay != '0) ? rec_in.start_delay : rec_in.period;
    end
  end

  always_comb begin
    rec_out      = rec_in;
    res.expire   = 1'b0;
    res.read_hit = 1'b0;
    unique case (cmd.opcode)
      ptb_pkg::OP_TICK: begin
        if (class_ok && active) begin
          if (rec_in.remaining != '0) begin
            rec_out.remaining = rec_in.remaining - 1'b1;
          end
          if (rec_in.remaining == '0 || rec_in.remaining == ptb_pkg::data_t'(1)) begin
            res.expire = 1'b1;
            if (rec_in.period != '0) begin
              rec_out.remaining = rec_in.period;
              rec_out.status    = ptb_pkg::ST_STARTED;
            end else begin
              rec_out.status    = ptb_pkg::ST_STOPPED;
            end
          end
        end
      end
      ptb_pkg::OP_SETUP: begin
        if (hit) begin
          rec_out.start_delay = cmd.start_delay;
          rec_out.period      = cmd.period;
          rec_out.hard        = cmd.hard_class;
          rec_out.remaining   = init_cnt;
          rec_out.status      = ptb_pkg::ST_CREATED;
        end
      end
      ptb_pkg::OP_START: begin
        if (hit && (rec_in.status == ptb_pkg::ST_CREATED ||
                    rec_in.status == ptb_pkg::ST_STOPPED)) begin
          rec_out.remaining = init_cnt;
          rec_out.status    = ptb_pkg::ST_STARTED;
        end
      end
      ptb_pkg::OP_STOP: begin
        if (hit && active) begin
          rec_out.status = ptb_pkg::ST_STOPPED;
        end
      end
      ptb_pkg::OP_DESTROY: begin
        if (hit) begin
          rec_out.status = ptb_pkg::ST_DESTROYED;
        end
      end
      ptb_pkg::OP_READ: begin
        res.read_hit = hit;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- design/periodic_timer_bank.sv -----
// Top level of the periodic timer bank: command sequencer, ring of slot
// cells and result output. Depends on ptb_pkg, ptb_cell and ptb_update.

// The slot records sit in a ring of TIMER_SLOTS cells that rotates one place
// per cycle in the walk state past a single update unit, so every command
// walks the whole bank. Set up, start, stop, destroy, read info and unknown
// opcodes keep busy high for one walk of the ring and the flush state; a tick
// walks the ring twice, hard class first, before the flush. Results appear
// on out_item for a single cycle with out_strobe high and cannot be stalled;
// the receiver must take each one as it comes. A tick reports up to 16 expiry
// events, in order of hard class first and then ascending slot, with last set
// on the final one; a tick without expiries gives no result. A read info gives
// exactly one result. Reset clears every slot to unused.
module periodic_timer_bank (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ptb_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output ptb_pkg::out_item_t  out_item
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  ptb_pkg::in_item_t   cmd_r, cmd_nxt;
  ptb_pkg::idx_t       cnt_r, cnt_nxt;
  logic                pass_r, pass_nxt;
  logic                hold_v_r, hold_v_nxt;
  ptb_pkg::slot_t      hold_slot_r, hold_slot_nxt;
  logic                hold_hard_r, hold_hard_nxt;
  ptb_pkg::evt_cnt_t   evt_cnt_r, evt_cnt_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  ptb_pkg::out_item_t  out_item_r, out_item_nxt;

  ptb_pkg::slot_rec_t  ring [ptb_pkg::TIMER_SLOTS];
  ptb_pkg::slot_rec_t  upd_rec;
  ptb_pkg::upd_res_t   upd_res;
  logic                shift_en;
  logic                walk_end;
  logic                report;
  logic                slot_in_bank;

  assign shift_en = (state_r == S_WALK);

  for (genvar i = 0; i < ptb_pkg::TIMER_SLOTS; i++) begin : g_cell
    if (i == ptb_pkg::TIMER_SLOTS - 1) begin : g_tail
      ptb_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .rec_in   (upd_rec),
        .rec_out  (ring[i])
      );
    end else begin : g_body
      ptb_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .rec_in   (ring[i+1]),
        .rec_out  (ring[i])
      );
    end
  end

  ptb_update u_update (
    .cmd       (cmd_r),
    .head_idx  (cnt_r),
    .pass_soft (pass_r),
    .rec_in    (ring[0]),
    .rec_out   (upd_rec),
    .res       (upd_res)
  );

  assign slot_in_bank = (ptb_pkg::cmp_t'(cmd_r.slot) <
                         ptb_pkg::cmp_t'(ptb_pkg::TIMER_SLOTS));
  assign walk_end = (cnt_r == ptb_pkg::idx_t'(ptb_pkg::TIMER_SLOTS - 1)) &&
                    (pass_r || cmd_r.opcode != ptb_pkg::OP_TICK);
  // Slots past the event limit are still updated but not reported.
  assign report   = shift_en && upd_res.expire &&
                    (evt_cnt_r < ptb_pkg::evt_cnt_t'(ptb_pkg::MAX_RES));

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    cnt_nxt        = cnt_r;
    pass_nxt       = pass_r;
    hold_v_nxt     = hold_v_r;
    hold_slot_nxt  = hold_slot_r;
    hold_hard_nxt  = hold_hard_r;
    evt_cnt_nxt    = evt_cnt_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt     = in_item;
          cnt_nxt     = '0;
          pass_nxt    = 1'b0;
          hold_v_nxt  = 1'b0;
          evt_cnt_nxt = '0;
          state_nxt   = S_WALK;
        end
      end
      S_WALK: begin
        // An expiry is held back until the next one is reported so that last can be set on the
        // final event once the walk is over.
        if (report) begin
          if (hold_v_r) begin
            out_strobe_nxt = 1'b1;
            out_item_nxt   = '0;
            out_item_nxt.kind       = ptb_pkg::KIND_EXPIRY;
            out_item_nxt.event_slot = hold_slot_r;
            out_item_nxt.event_hard = hold_hard_r;
          end
          hold_v_nxt    = 1'b1;
          hold_slot_nxt = ptb_pkg::slot_t'(cnt_r);
          hold_hard_nxt = ring[0].hard;
          evt_cnt_nxt   = evt_cnt_r + 1'b1;
        end
        if (upd_res.read_hit) begin
          out_strobe_nxt = 1'b1;
          out_item_nxt.kind             = ptb_pkg::KIND_INFO;
          out_item_nxt.event_slot       = cmd_r.slot;
          out_item_nxt.event_hard       = ring[0].hard;
          out_item_nxt.info_start_delay = ring[0].start_delay;
          out_item_nxt.info_period      = ring[0].period;
          out_item_nxt.info_state       = ring[0].status;
          out_item_nxt.last             = 1'b1;
        end
        if (cnt_r == ptb_pkg::idx_t'(ptb_pkg::TIMER_SLOTS - 1)) begin
          cnt_nxt  = '0;
          pass_nxt = 1'b1;
        end else begin
          cnt_nxt  = cnt_r + 1'b1;
        end
        if (walk_end) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (cmd_r.opcode == ptb_pkg::OP_TICK && hold_v_r) begin
          out_strobe_nxt = 1'b1;
          out_item_nxt   = '0;
          out_item_nxt.kind       = ptb_pkg::KIND_EXPIRY;
          out_item_nxt.event_slot = hold_slot_r;
          out_item_nxt.event_hard = hold_hard_r;
          out_item_nxt.last       = 1'b1;
        end else if (cmd_r.opcode == ptb_pkg::OP_READ && !slot_in_bank) begin
          out_strobe_nxt = 1'b1;
          out_item_nxt   = '0;
          out_item_nxt.kind       = ptb_pkg::KIND_INFO;
          out_item_nxt.event_slot = cmd_r.slot;
          out_item_nxt.info_state = ptb_pkg::ST_UNUSED;
          out_item_nxt.last       = 1'b1;
        end
        hold_v_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      pass_r       <= 1'b0;
      hold_v_r     <= 1'b0;
      evt_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pass_r       <= pass_nxt;
      hold_v_r     <= hold_v_nxt;
      evt_cnt_r    <= evt_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    hold_slot_r <= hold_slot_nxt;
    hold_hard_r <= hold_hard_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// ----- tb/ptb_checker.sv -----
// Result checker for the periodic timer bank: tracks every accepted command,
// predicts the expiry and readback results and compares them as they appear.
// Depends on ptb_pkg.
module ptb_checker
  import ptb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_strobe,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending,
  output int        n_cmds,
  output int        n_ticks,
  output int        n_expiry,
  output int        n_info
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted copy of the bank.
  data_t      slot_delay  [TIMER_SLOTS];
  data_t      slot_reload [TIMER_SLOTS];
  data_t      slot_count  [TIMER_SLOTS];
  logic       slot_hard   [TIMER_SLOTS];
  logic [2:0] slot_state  [TIMER_SLOTS];

  out_item_t  expected_events[$];

  int fails    = 0;
  int shown    = 0;
  int cmds     = 0;
  int ticks    = 0;
  int expiries = 0;
  int infos    = 0;

  function automatic void clear_bank();
    for (int s = 0; s < TIMER_SLOTS; s++) begin
      slot_delay[s]  = '0;
      slot_reload[s] = '0;
      slot_count[s]  = '0;
      slot_hard[s]   = 1'b0;
      slot_state[s]  = ST_UNUSED;
    end
  endfunction

  function automatic data_t first_count(int s);
    return (slot_delay[s] != '0) ? slot_delay[s] : slot_reload[s];
  endfunction

  function automatic logic is_armed(int s);
    return (slot_state[s] == ST_STARTED) || (slot_state[s] == ST_RUNNING);
  endfunction

  // Hard-class slots are served first, then soft-class, each in slot order.
  function automatic void walk_tick();
    int        n;
    logic      want;
    logic      fired;
    out_item_t ev;
    n = 0;
    for (int pass = 0; pass < 2; pass++) begin
      want = (pass == 0);
      for (int s = 0; s < TIMER_SLOTS; s++) begin
        if (slot_hard[s] == want && is_armed(s)) begin
          fired = (slot_count[s] == '0);
          if (!fired) begin
            slot_count[s] = slot_count[s] - 1'b1;
            fired = (slot_count[s] == '0);
          end
          if (fired) begin
            if (n < MAX_RES) begin
              ev = '0;
              ev.kind = KIND_EXPIRY;
              ev.event_slot = slot_t'(s);
              ev.event_hard = slot_hard[s];
              expected_events.push_back(ev);
              n++;
            end
            if (slot_reload[s] != '0) begin
              slot_count[s] = slot_reload[s];
              slot_state[s] = ST_STARTED;
            end else begin
              slot_state[s] = ST_STOPPED;
            end
          end
        end
      end
    end
    if (n > 0) begin
      ev = expected_events.pop_back();
      ev.last = 1'b1;
      expected_events.push_back(ev);
    end
  endfunction

  function automatic void predict_results(in_item_t it);
    int        s;
    logic      ok;
    out_item_t ev;
    s  = int'(it.slot);
    ok = (s < TIMER_SLOTS);
    case (it.opcode)
      OP_TICK: begin
        ticks++;
        walk_tick();
      end
      OP_SETUP: begin
        if (ok) begin
          slot_delay[s]  = it.start_delay;
          slot_reload[s] = it.period;
          slot_hard[s]   = it.hard_class;
          slot_count[s]  = first_count(s);
          slot_state[s]  = ST_CREATED;
        end
      end
      OP_START: begin
        if (ok && (slot_state[s] == ST_CREATED || slot_state[s] == ST_STOPPED)) begin
          slot_count[s] = first_count(s);
          slot_state[s] = ST_STARTED;
        end
      end
      OP_STOP: begin
        if (ok && is_armed(s)) slot_state[s] = ST_STOPPED;
      end
      OP_DESTROY: begin
        if (ok) slot_state[s] = ST_DESTROYED;
      end
      OP_READ: begin
        ev = '0;
        ev.kind = KIND_INFO;
        ev.event_slot = it.slot;
        ev.info_state = ST_UNUSED;
        ev.last = 1'b1;
        if (ok) begin
          ev.event_hard       = slot_hard[s];
          ev.info_start_delay = slot_delay[s];
          ev.info_period      = slot_reload[s];
          ev.info_state       = slot_state[s];
        end
        expected_events.push_back(ev);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    logic      bad;
    if (expected_events.size() == 0) begin
      fails++;
      if (shown < 10) begin
        shown++;
        $display("[%0t] unexpected result: kind %0d slot %0d hard %0d last %0d",
                 $realtime, got.kind, got.event_slot, got.event_hard, got.last);
      end
    end else begin
      want = expected_events.pop_front();
      bad = (got.kind !== want.kind) || (got.event_slot !== want.event_slot) ||
            (got.event_hard !== want.event_hard) ||
            (got.info_start_delay !== want.info_start_delay) ||
            (got.info_period !== want.info_period) ||
            (got.info_state !== want.info_state) || (got.last !== want.last);
      if (bad) begin
        fails++;
        if (shown < 10) begin
          shown++;
          $display("[%0t] mismatch: expected kind %0d slot %0d hard %0d delay %h period %h state %0d last %0d",
                   $realtime, want.kind, want.event_slot, want.event_hard,
                   want.info_start_delay, want.info_period, want.info_state, want.last);
          $display("             actual   kind %0d slot %0d hard %0d delay %h period %h state %0d last %0d",
                   got.kind, got.event_slot, got.event_hard,
                   got.info_start_delay, got.info_period, got.info_state, got.last);
        end
      end else if (got.kind == KIND_EXPIRY) begin
        expiries++;
      end else begin
        infos++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_bank();
      expected_events.delete();
    end else begin
      if (out_strobe) check_result(out_item);
      if (start && !busy) begin
        cmds++;
        predict_results(in_item);
      end
    end
    fail_count <= fails;
    pending    <= expected_events.size();
    n_cmds     <= cmds;
    n_ticks    <= ticks;
    n_expiry   <= expiries;
    n_info     <= infos;
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the periodic timer bank: clock, reset, directed and
// random command stimulus, and the final verdict.
// Depends on ptb_pkg, periodic_timer_bank and ptb_checker.
module tb;
  import ptb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes the block has no meaning for.
  localparam logic [2:0] OP_UNDEF_A = 3'd6;
  localparam logic [2:0] OP_UNDEF_B = 3'd7;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;

  int fail_count;
  int pending;
  int n_cmds;
  int n_ticks;
  int n_expiry;
  int n_info;

  periodic_timer_bank u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  ptb_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending),
    .n_cmds     (n_cmds),
    .n_ticks    (n_ticks),
    .n_expiry   (n_expiry),
    .n_info     (n_info)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic in_item_t make_cmd(logic [2:0] op, slot_t s, data_t sd, data_t per,
                                        logic hard);
    in_item_t it;
    it.opcode      = op;
    it.slot        = s;
    it.start_delay = sd;
    it.period      = per;
    it.hard_class  = hard;
    return it;
  endfunction

  // Mostly small counts so that slots expire often; now and then a full word.
  function automatic data_t rand_count();
    int r;
    r = $urandom_range(99);
    if (r < 75) return data_t'($urandom_range(4));
    if (r < 90) return '0;
    return data_t'($urandom());
  endfunction

  function automatic in_item_t random_cmd();
    int       r;
    slot_t    s;
    logic [2:0] op;
    r = $urandom_range(99);
    s = slot_t'($urandom_range(TIMER_SLOTS - 1));
    if      (r < 35) op = OP_TICK;
    else if (r < 55) op = OP_SETUP;
    else if (r < 72) op = OP_START;
    else if (r < 82) op = OP_STOP;
    else if (r < 87) op = OP_DESTROY;
    else if (r < 97) op = OP_READ;
    else             op = $urandom_range(1) ? OP_UNDEF_A : OP_UNDEF_B;
    return make_cmd(op, s, rand_count(), rand_count(), logic'($urandom_range(1)));
  endfunction

  // Presents one item and returns at the edge where it is taken. Each idle
  // step lasts until an edge at which the block could have taken an item.
  task automatic send_cmd(input in_item_t it, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while (busy) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    int idle_pct;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: state transitions, ignored commands and extreme values.
    send_cmd(make_cmd(OP_READ,    4'd0,  '0, '0, 1'b0), 0);
    send_cmd(make_cmd(OP_SETUP,   4'd0,  '0, '0, 1'b1), 0);
    send_cmd(make_cmd(OP_START,   4'd3,  '0, '0, 1'b0), 0);
    send_cmd(make_cmd(OP_STOP,    4'd0,  '0, '0, 1'b0), 0);
    send_cmd(make_cmd(OP_START,   4'd0,  '0, '0, 1'b0), 0);
    send_cmd(make_cmd(OP_SETUP,   4'd15, 32'd1, 32'd2, 1'b0), 0);
    send_cmd(make_cmd(OP_START,   4'd15, '0, '0, 1'b0), 0);
    send_cmd(make_cmd(OP_SETUP,   4'd5,  32'd2, 32'd1, 1'b1), 0);
    send_cmd(make_cmd(OP_START,   4'd5,  '0, '0, 1'b0), 0);
    send_cmd(make_cmd(OP_START,   4'd5,  '0, '0, 1'b0), 0);
    send_cmd(make_cmd(OP_TICK,    4'd0,  '0, '0, 1'b0), 0);
    send_cmd(make_cmd(OP_TICK,    4'd15, '1, '1, 1'b1), 0);
    send_cmd(make_cmd(OP_READ,    4'd0,  '0, '0, 1'b0), 0);
    send_cmd(make_cmd(OP_READ,    4'd15, '0, '0, 1'b0), 0);
    send_cmd(make_cmd(OP_SETUP,   4'd7,  '1, '1, 1'b1), 0);
    send_cmd(make_cmd(OP_READ,    4'd7,  '1, '1, 1'b1), 0);
    send_cmd(make_cmd(OP_STOP,    4'd15, '0, '0, 1'b0), 0);
    send_cmd(make_cmd(OP_START,   4'd15, '0, '0, 1'b0), 0);
    send_cmd(make_cmd(OP_DESTROY, 4'd5,  '0, '0, 1'b0), 0);
    send_cmd(make_cmd(OP_START,   4'd5,  '0, '0, 1'b0), 0);
    // Set up on an armed slot takes it out of the active set.
    send_cmd(make_cmd(OP_SETUP,   4'd15, '0, 32'd3, 1'b0), 0);
    send_cmd(make_cmd(OP_UNDEF_A, 4'd1,  '1, '1, 1'b1), 0);
    send_cmd(make_cmd(OP_UNDEF_B, 4'd2,  '0, '0, 1'b0), 0);
    send_cmd(make_cmd(OP_TICK,    4'd0,  '0, '0, 1'b0), 0);
    send_cmd(make_cmd(OP_READ,    4'd5,  '0, '0, 1'b0), 0);

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 17 : (ph == 1) ? 46 : 0;
      for (int i = 0; i < 100; i++) send_cmd(random_cmd(), idle_pct);
    end
    start <= 1'b0;

    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d commands, %0d of them ticks; checked %0d expiries, %0d readbacks.",
             n_cmds, n_ticks, n_expiry, n_info);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still expected.", pending);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
